### sv/occm_pkg.sv
package occm_pkg;

	// fixed field widths
	localparam int PIX_W      = 32;
	localparam int FRAC_W     = 17;
	localparam int WHITE_W    = 25;
	localparam int CFG_DIM_W  = 13;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int M_TDATA_W  = 48;
	localparam int M_TUSER_W  = 2;

	localparam int DEF_MAX_DIM = 4096;

	localparam logic [PIX_W-1:0]   WHITE_PIXEL  = '1;
	localparam logic [WHITE_W-1:0] WHITE_LIMIT  = 25'd16777216;
	localparam logic [FRAC_W-1:0]  ONE_Q16      = 17'd65536;
	localparam logic [FRAC_W-1:0]  MIN_FRACTION = 17'd655;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH        = 2'd0,
		REG_IMAGE_HEIGHT       = 2'd1,
		REG_REFERENCE_FRACTION = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_MUL_WH,
		SEQ_MUL_REF,
		SEQ_SUB,
		SEQ_DIV,
		SEQ_DONE
	} seq_state_t;

	// running totals after the pixel being accepted
	typedef struct packed {
		logic [WHITE_W-1:0] white_count;
		logic               is_clipped;
	} frame_sum_t;

	typedef struct packed {
		logic [FRAC_W-1:0]  occlusion_fraction;
		logic [WHITE_W-1:0] white_count;
		logic               is_clipped;
		logic               no_pixels;
	} result_t;

endpackage

### sv/mask_occlusion_and_clip_measure_unit.sv
// channel   dir  handshake              payload
// s_        in   s_tvalid / s_tready    s_tdata: pixel_rgba[31:0]; s_tlast: frame_last
// m_        out  m_tvalid / m_tready    m_tdata: occlusion_fraction[16:0], white_count[41:17]
//                                       m_tuser: is_clipped[0], no_pixels[1]
// cfg_      in   cfg_valid / cfg_ready  cfg_index: register, cfg_data: value
//
// a pixel without s_tlast is taken at one pixel every cycle while the sequencer is idle
// a pixel with s_tlast starts the end-of-frame sequence: w*h and ref*total by
// shift-and-add, one subtract and a 17-step restoring divide, all on one shared
// adder; s_tready is low until the sequencer is idle again, and the divide is
// skipped when the frame has no white pixel or the numerator is negative
// the result sits in an output register; a stalled m_tready with that register
// still full keeps the sequencer in its done state and the input side not ready
// arst_n clears position, counts and flags and loads 640 x 480, reference 0
module mask_occlusion_and_clip_measure_unit import occm_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // pixel_rgba
	input  logic                  s_tlast,   // frame_last
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // occlusion_fraction, white_count, zero pad
	output logic [M_TUSER_W-1:0]  m_tuser,   // is_clipped, no_pixels
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CMP_W = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;

	// configuration registers, as written
	logic [CFG_DIM_W-1:0] image_width_q;
	logic [CFG_DIM_W-1:0] image_height_q;
	logic [FRAC_W-1:0]    reference_fraction_q;

	// clamped values seen by the datapath
	logic [DIM_W-1:0]  width_cl;
	logic [DIM_W-1:0]  height_cl;
	logic [FRAC_W-1:0] ref_cl;

	logic       in_accept;
	logic       seq_idle;
	logic       res_valid;
	logic       res_take;
	frame_sum_t sum_nxt;
	result_t    res;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q        <= 13'd640;
			image_height_q       <= 13'd480;
			reference_fraction_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:        image_width_q        <= cfg_data[CFG_DIM_W-1:0];
				REG_IMAGE_HEIGHT:       image_height_q       <= cfg_data[CFG_DIM_W-1:0];
				REG_REFERENCE_FRACTION: reference_fraction_q <= cfg_data;
				default: begin
					image_width_q <= image_width_q;
				end
			endcase
		end
	end

	// zero acts as one, anything past MAX_DIM as MAX_DIM
	always_comb begin
		if (image_width_q == '0) begin
			width_cl = DIM_W'(1);
		end else if (CMP_W'(image_width_q) > CMP_W'(MAX_DIM)) begin
			width_cl = DIM_W'(MAX_DIM);
		end else begin
			width_cl = DIM_W'(image_width_q);
		end
		if (image_height_q == '0) begin
			height_cl = DIM_W'(1);
		end else if (CMP_W'(image_height_q) > CMP_W'(MAX_DIM)) begin
			height_cl = DIM_W'(MAX_DIM);
		end else begin
			height_cl = DIM_W'(image_height_q);
		end
		ref_cl = (reference_fraction_q > ONE_Q16) ? ONE_Q16 : reference_fraction_q;
	end

	// pixels only flow while the sequencer is parked
	assign s_tready  = seq_idle;
	assign in_accept = s_tvalid && s_tready;

	occm_track #(
		.MAX_DIM (MAX_DIM),
		.DIM_W   (DIM_W)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.pixel      (s_tdata),
		.last       (s_tlast),
		.img_width  (width_cl),
		.img_height (height_cl),
		.sum_nxt    (sum_nxt)
	);

	occm_seq #(
		.MAX_DIM (MAX_DIM),
		.DIM_W   (DIM_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_accept && s_tlast),
		.sum_in     (sum_nxt),
		.img_width  (width_cl),
		.img_height (height_cl),
		.ref_frac   (ref_cl),
		.idle       (seq_idle),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	// output register, refilled as soon as the previous item leaves
	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_tdata_q <= M_TDATA_W'({res.white_count, res.occlusion_fraction});
			m_tuser_q <= {res.no_pixels, res.is_clipped};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### sv/occm_track.sv
module occm_track import occm_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM,
	parameter int DIM_W   = $clog2(MAX_DIM + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [PIX_W-1:0] pixel,
	input  logic             last,
	input  logic [DIM_W-1:0] img_width,
	input  logic [DIM_W-1:0] img_height,
	output frame_sum_t       sum_nxt
);

	localparam int POS_W = $clog2(MAX_DIM);

	logic [POS_W-1:0]   column_pos_q;
	logic [POS_W-1:0]   row_pos_q;
	logic [WHITE_W-1:0] white_q;
	logic               clip_q;

	logic [DIM_W-1:0] w_m1;
	logic [DIM_W-1:0] h_m1;
	logic             col_end;
	logic             row_end;
	logic             is_white;
	logic             on_border;

	assign w_m1      = img_width - DIM_W'(1);
	assign h_m1      = img_height - DIM_W'(1);
	assign col_end   = DIM_W'(column_pos_q) >= w_m1;
	assign row_end   = DIM_W'(row_pos_q) >= h_m1;
	assign is_white  = pixel == WHITE_PIXEL;
	assign on_border = column_pos_q == '0 || col_end || row_pos_q == '0 || row_end;

	always_comb begin
		sum_nxt.white_count = white_q;
		sum_nxt.is_clipped  = clip_q;
		if (is_white) begin
			if (white_q < WHITE_LIMIT) begin
				sum_nxt.white_count = white_q + WHITE_W'(1);
			end
			if (on_border) begin
				sum_nxt.is_clipped = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_pos_q <= '0;
			row_pos_q    <= '0;
			white_q      <= '0;
			clip_q       <= 1'b0;
		end else if (accept) begin
			if (last) begin
				column_pos_q <= '0;
				row_pos_q    <= '0;
				white_q      <= '0;
				clip_q       <= 1'b0;
			end else begin
				white_q <= sum_nxt.white_count;
				clip_q  <= sum_nxt.is_clipped;
				if (col_end) begin
					column_pos_q <= '0;
					row_pos_q    <= row_end ? '0 : row_pos_q + POS_W'(1);
				end else begin
					column_pos_q <= column_pos_q + POS_W'(1);
				end
			end
		end
	end

endmodule

### sv/occm_seq.sv
module occm_seq import occm_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM,
	parameter int DIM_W   = $clog2(MAX_DIM + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  frame_sum_t        sum_in,
	input  logic [DIM_W-1:0]  img_width,
	input  logic [DIM_W-1:0]  img_height,
	input  logic [FRAC_W-1:0] ref_frac,
	output logic              idle,
	output logic              res_valid,
	input  logic              res_take,
	output result_t           res
);

	localparam int PROD_W = 2 * DIM_W + FRAC_W;
	localparam int ACC_W  = (PROD_W > WHITE_W + FRAC_W) ? PROD_W : WHITE_W + FRAC_W;
	localparam int MPL_W  = (DIM_W > FRAC_W) ? DIM_W : FRAC_W;
	localparam int CNT_W  = $clog2(MPL_W);

	seq_state_t state_q, state_d;

	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   opnd_q;
	logic [MPL_W-1:0]   mplr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [WHITE_W-1:0] rem_q;
	logic [FRAC_W-1:0]  quo_q;
	logic [WHITE_W-1:0] white_q;
	logic               clip_q;

	// the one shared add / subtract unit
	logic [ACC_W-1:0] op_a;
	logic [ACC_W-1:0] op_b;
	logic             op_sub;
	logic [ACC_W:0]   sum_w;
	logic             carry;

	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		case (state_q)
			SEQ_MUL_WH, SEQ_MUL_REF: begin
				op_a = {acc_q[ACC_W-2:0], 1'b0};
				op_b = mplr_q[MPL_W-1] ? opnd_q : '0;
			end
			SEQ_SUB: begin
				op_a   = ACC_W'({white_q, 16'b0});
				op_b   = acc_q;
				op_sub = 1'b1;
			end
			SEQ_DIV: begin
				op_a   = ACC_W'({rem_q, quo_q[FRAC_W-1]});
				op_b   = ACC_W'(white_q);
				op_sub = 1'b1;
			end
			default: begin
				op_sub = 1'b0;
			end
		endcase
	end

	assign sum_w = {1'b0, op_a} + {1'b0, op_sub ? ~op_b : op_b} + (ACC_W + 1)'(op_sub);
	assign carry = sum_w[ACC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		idle      = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			SEQ_IDLE: begin
				idle = 1'b1;
				if (start) begin
					state_d = SEQ_MUL_WH;
				end
			end
			SEQ_MUL_WH: begin
				if (cnt_q == '0) begin
					state_d = SEQ_MUL_REF;
				end
			end
			SEQ_MUL_REF: begin
				if (cnt_q == '0) begin
					state_d = SEQ_SUB;
				end
			end
			SEQ_SUB: begin
				state_d = (white_q == '0 || !carry) ? SEQ_DONE : SEQ_DIV;
			end
			SEQ_DIV: begin
				if (cnt_q == '0) begin
					state_d = SEQ_DONE;
				end
			end
			SEQ_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (state_q)
				SEQ_IDLE: begin
					cnt_q <= CNT_W'(MPL_W - 1);
				end
				SEQ_MUL_WH: begin
					cnt_q <= (cnt_q == '0) ? CNT_W'(MPL_W - 1) : cnt_q - CNT_W'(1);
				end
				SEQ_SUB: begin
					cnt_q <= CNT_W'(FRAC_W - 1);
				end
				SEQ_MUL_REF, SEQ_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					white_q <= sum_in.white_count;
					clip_q  <= sum_in.is_clipped;
					acc_q   <= '0;
					opnd_q  <= ACC_W'(img_width);
					mplr_q  <= MPL_W'(img_height);
				end
			end
			SEQ_MUL_WH: begin
				mplr_q <= {mplr_q[MPL_W-2:0], 1'b0};
				acc_q  <= sum_w[ACC_W-1:0];
				if (cnt_q == '0) begin
					// product w*h becomes the multiplicand for the reference
					opnd_q <= sum_w[ACC_W-1:0];
					acc_q  <= '0;
					mplr_q <= MPL_W'(ref_frac);
				end
			end
			SEQ_MUL_REF: begin
				mplr_q <= {mplr_q[MPL_W-2:0], 1'b0};
				acc_q  <= sum_w[ACC_W-1:0];
			end
			SEQ_SUB: begin
				if (white_q == '0 || !carry) begin
					quo_q <= '0;
				end else begin
					// numerator below white << 17, so the top part fits the remainder
					rem_q <= sum_w[FRAC_W +: WHITE_W];
					quo_q <= sum_w[FRAC_W-1:0];
				end
			end
			SEQ_DIV: begin
				rem_q <= carry ? sum_w[WHITE_W-1:0] : {rem_q[WHITE_W-2:0], quo_q[FRAC_W-1]};
				quo_q <= {quo_q[FRAC_W-2:0], carry};
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	always_comb begin
		res.occlusion_fraction = (quo_q < MIN_FRACTION) ? '0 : quo_q;
		res.white_count        = white_q;
		res.is_clipped         = clip_q;
		res.no_pixels          = white_q == '0;
	end

endmodule

### sv/occm_check.sv
module occm_check import occm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  s_tlast,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [M_TDATA_W-1:0]  m_tdata,
	input logic [M_TUSER_W-1:0]  m_tuser
);

	// held result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// frame end starts the end-of-frame sequence, so the input goes busy
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("pixel taken during end-of-frame sequence");

	// empty frame gives zero fraction, zero count and no clip flag
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[16:0] == '0 && m_tdata[41:17] == '0 && !m_tuser[0])
		else $error("empty frame with non-zero result");

	// fraction is zero or between 655 / 65536 (about 0.01) and 1.0
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[16:0] == '0 ||
			(m_tdata[16:0] >= MIN_FRACTION && m_tdata[16:0] <= ONE_Q16))
		else $error("fraction out of range");

endmodule

bind mask_occlusion_and_clip_measure_unit occm_check u_occm_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### dv/mask_occlusion_and_clip_measure_unit_tb.sv
`timescale 1ns / 100ps

module mask_occlusion_and_clip_measure_unit_tb;
	import occm_pkg::*;

	// end-of-frame sequence length at the default size, plus a margin
	localparam int SEQ_CYCLES     = 53;
	localparam int SETTLE_CYCLES  = SEQ_CYCLES + 8;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_PIXELS  = 1400;
	localparam logic [15:0] STALL_PATTERN = 16'b1011_0011_1000_1101;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_PATTERN,
		RX_RANDOM
	} rx_mode_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata   = '0;   // pixel_rgba
	logic                  s_tlast   = 1'b0; // frame_last
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;          // occlusion_fraction, white_count, zero pad
	logic [M_TUSER_W-1:0]  m_tuser;          // is_clipped, no_pixels
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	mask_occlusion_and_clip_measure_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the registers, loaded with the reset values
	logic [CFG_DIM_W-1:0]  width_reg  = 13'd640;
	logic [CFG_DIM_W-1:0]  height_reg = 13'd480;
	logic [CFG_DATA_W-1:0] ref_reg    = '0;

	// predictor copy of the frame state
	int unsigned        scan_col   = 0;
	int unsigned        scan_row   = 0;
	logic [WHITE_W-1:0] white_run  = '0;
	logic               border_hit = 1'b0;

	result_t pending_measures[$];
	result_t got_measure;
	result_t want_measure;

	int          errors      = 0;
	int unsigned quiet_count = 0;
	int unsigned burst_left  = 0;
	bit          sender_gaps = 1'b0;
	rx_mode_t    rx_mode     = RX_ALWAYS;
	logic [3:0]  stall_phase = '0;

	function automatic int unsigned clamp_dim(logic [CFG_DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > DEF_MAX_DIM)
			return DEF_MAX_DIM;
		return 32'(v);
	endfunction

	// advance the frame state by one pixel, queue the measure on the frame's last pixel
	function automatic void measure_pixel(logic [PIX_W-1:0] pix, logic last);
		int unsigned w;
		int unsigned h;
		int unsigned rf;
		longint      num;
		longint      q;
		result_t     r;
		w  = clamp_dim(width_reg);
		h  = clamp_dim(height_reg);
		rf = (ref_reg > ONE_Q16) ? 32'(ONE_Q16) : 32'(ref_reg);
		if (pix == WHITE_PIXEL) begin
			if (white_run < WHITE_LIMIT)
				white_run++;
			if (scan_col == 0 || scan_col >= w - 1 || scan_row == 0 || scan_row >= h - 1)
				border_hit = 1'b1;
		end
		// positions past the frame wrap, rows past the end count as border rows
		if (scan_col >= w - 1) begin
			scan_col = 0;
			if (scan_row >= h - 1)
				scan_row = 0;
			else
				scan_row++;
		end else begin
			scan_col++;
		end
		if (!last)
			return;
		r.occlusion_fraction = '0;
		r.no_pixels          = (white_run == 0);
		r.white_count        = white_run;
		r.is_clipped         = border_hit;
		if (!r.no_pixels) begin
			num = longint'(white_run) * 65536 - longint'(rf) * longint'(w) * longint'(h);
			if (num >= 0) begin
				q = num / longint'(white_run);
				if (q > 65536)
					q = 65536;
				// shares under one percent read as zero
				if (q >= MIN_FRACTION)
					r.occlusion_fraction = q[FRAC_W-1:0];
			end
		end
		pending_measures.push_back(r);
		scan_col   = 0;
		scan_row   = 0;
		white_run  = '0;
		border_hit = 1'b0;
	endfunction

	// one pixel item; with sender_gaps set the sender runs in bursts with short gaps between them
	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
		int unsigned gap;
		gap = 0;
		if (sender_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap        = $urandom_range(1, 5);
			end
			burst_left--;
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		measure_pixel(pix, last);
	endtask

	// hold the input, let every queued measure arrive and the sequencer settle
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_measures.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		wait_drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:        width_reg  = val[CFG_DIM_W-1:0];
			REG_IMAGE_HEIGHT:       height_reg = val[CFG_DIM_W-1:0];
			REG_REFERENCE_FRACTION: ref_reg    = val;
			default: ;
		endcase
	endtask

	// reset size 640 x 480: near-white values, a white pixel on the top row, an empty frame
	task automatic test_reset_defaults();
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'hFFFF_FFFE, 1'b0);
		send_pixel(32'h7FFF_FFFF, 1'b0);
		send_pixel(WHITE_PIXEL, 1'b1);
		send_pixel(32'hFEFF_FFFF, 1'b1);
	endtask

	// 3 x 3 frame with white only in the centre, so no border is touched
	task automatic test_interior_only();
		int i;
		write_reg(REG_IMAGE_WIDTH, 17'd3);
		write_reg(REG_IMAGE_HEIGHT, 17'd3);
		for (i = 0; i < 9; i++)
			send_pixel((i == 4) ? WHITE_PIXEL : 32'h00FF_FFFF, i == 8);
	endtask

	// 2 x 2 frame given too many pixels: column and row wrap past the end
	task automatic test_position_wrap();
		int i;
		write_reg(REG_IMAGE_WIDTH, 17'd2);
		write_reg(REG_IMAGE_HEIGHT, 17'd2);
		for (i = 0; i < 7; i++)
			send_pixel((i >= 4) ? WHITE_PIXEL : 32'h1234_5678, i == 6);
	endtask

	// width grows mid-frame, so a column that was the last one becomes interior
	task automatic test_size_change_mid_frame();
		int i;
		write_reg(REG_IMAGE_WIDTH, 17'd3);
		write_reg(REG_IMAGE_HEIGHT, 17'd3);
		for (i = 0; i < 5; i++)
			send_pixel((i == 4) ? WHITE_PIXEL : 32'h0, 1'b0);
		write_reg(REG_IMAGE_WIDTH, 17'd5);
		send_pixel(WHITE_PIXEL, 1'b0);
		send_pixel(32'h0, 1'b0);
		send_pixel(32'hFFFF_FF00, 1'b1);
	endtask

	// 1 x 1 frames, one white pixel each: the share is 65536 - reference
	task automatic test_fraction_threshold();
		write_reg(REG_IMAGE_WIDTH, 17'd1);
		write_reg(REG_IMAGE_HEIGHT, 17'd1);
		write_reg(REG_REFERENCE_FRACTION, 17'd64881);   // just at one percent
		send_pixel(WHITE_PIXEL, 1'b1);
		write_reg(REG_REFERENCE_FRACTION, 17'd64882);   // just below, reads as zero
		send_pixel(WHITE_PIXEL, 1'b1);
		write_reg(REG_REFERENCE_FRACTION, 17'd65536);   // numerator exactly zero
		send_pixel(WHITE_PIXEL, 1'b1);
		write_reg(REG_REFERENCE_FRACTION, 17'd131071);  // above one, acts as one
		send_pixel(WHITE_PIXEL, 1'b1);
	endtask

	// zero sizes act as 1, sizes above the maximum act as the maximum
	task automatic test_dimension_clamp();
		write_reg(REG_REFERENCE_FRACTION, 17'd0);
		write_reg(REG_IMAGE_WIDTH, 17'd0);
		write_reg(REG_IMAGE_HEIGHT, 17'd0);
		send_pixel(32'h8000_0000, 1'b0);
		send_pixel(WHITE_PIXEL, 1'b1);
		write_reg(REG_IMAGE_WIDTH, 17'h1FFFF);
		write_reg(REG_IMAGE_HEIGHT, 17'd4097);
		write_reg(REG_REFERENCE_FRACTION, 17'd1);
		send_pixel(WHITE_PIXEL, 1'b0);
		send_pixel(WHITE_PIXEL, 1'b1);
	endtask

	// mostly whole frames of small random size, some short or overlong ones,
	// a few huge sizes with short frames, random densities and references
	task automatic test_random_frames();
		int unsigned sent;
		int unsigned area;
		int unsigned frame_len;
		int unsigned white_pct;
		int unsigned i;
		logic [PIX_W-1:0] pix;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			if ($urandom_range(0, 3) == 0) begin
				if ($urandom_range(0, 9) == 0)
					write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, 131071)));
				else
					write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(1, 8)));
				if ($urandom_range(0, 9) == 0)
					write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 131071)));
				else
					write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(1, 8)));
			end
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 5))
					0: write_reg(REG_REFERENCE_FRACTION, 17'd0);
					1: write_reg(REG_REFERENCE_FRACTION, 17'd65536);
					2: write_reg(REG_REFERENCE_FRACTION,
						CFG_DATA_W'($urandom_range(0, 131071)));
					default: write_reg(REG_REFERENCE_FRACTION,
						CFG_DATA_W'($urandom_range(0, 65535)));
				endcase
			end
			case ($urandom_range(0, 4))
				0: white_pct = 0;
				1: white_pct = 25;
				2: white_pct = 50;
				3: white_pct = 90;
				default: white_pct = 100;
			endcase
			sender_gaps = ($urandom_range(0, 3) != 0);
			rx_mode     = rx_mode_t'($urandom_range(0, 2));
			area = clamp_dim(width_reg) * clamp_dim(height_reg);
			if (area > 64)
				frame_len = $urandom_range(1, 48);
			else if ($urandom_range(0, 99) < 85)
				frame_len = area;
			else
				frame_len = $urandom_range(1, area + 6);
			for (i = 0; i < frame_len; i++) begin
				if ($urandom_range(0, 99) < white_pct)
					pix = WHITE_PIXEL;
				else if ($urandom_range(0, 3) == 0)
					pix = WHITE_PIXEL ^ (32'h1 << $urandom_range(0, 31));
				else
					pix = $urandom();
				send_pixel(pix, i == frame_len - 1);
			end
			sent += frame_len;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		rx_mode     = RX_PATTERN;
		sender_gaps = 1'b1;
		test_interior_only();
		test_position_wrap();
		rx_mode = RX_RANDOM;
		test_size_change_mid_frame();
		test_fraction_threshold();
		test_dimension_clamp();
		test_random_frames();
		wait_drain();
		if (errors == 0)
			$display("PASS mask_occlusion_and_clip_measure_unit");
		else
			$display("FAIL mask_occlusion_and_clip_measure_unit");
		$finish;
	end

	// result side: stall pattern of its own, check each item against the oldest measure
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready    <= 1'b0;
			stall_phase <= '0;
		end else begin
			stall_phase <= stall_phase + 1'b1;
			case (rx_mode)
				RX_ALWAYS:  m_tready <= 1'b1;
				RX_PATTERN: m_tready <= STALL_PATTERN[stall_phase];
				default:    m_tready <= ($urandom_range(0, 3) != 0);
			endcase
			if (m_tvalid && m_tready) begin
				got_measure.occlusion_fraction = m_tdata[FRAC_W-1:0];
				got_measure.white_count        = m_tdata[FRAC_W+WHITE_W-1:FRAC_W];
				got_measure.is_clipped         = m_tuser[0];
				got_measure.no_pixels          = m_tuser[1];
				if (pending_measures.size() == 0) begin
					$display("%0t result with none expected: got %p", $time, got_measure);
					errors++;
				end else begin
					want_measure = pending_measures.pop_front();
					if (got_measure.occlusion_fraction !== want_measure.occlusion_fraction) begin
						$display("%0t occlusion_fraction: expected %0d, got %0d", $time,
							want_measure.occlusion_fraction, got_measure.occlusion_fraction);
						errors++;
					end
					if (got_measure.white_count !== want_measure.white_count) begin
						$display("%0t white_count: expected %0d, got %0d", $time,
							want_measure.white_count, got_measure.white_count);
						errors++;
					end
					if (got_measure.is_clipped !== want_measure.is_clipped) begin
						$display("%0t is_clipped: expected %0b, got %0b", $time,
							want_measure.is_clipped, got_measure.is_clipped);
						errors++;
					end
					if (got_measure.no_pixels !== want_measure.no_pixels) begin
						$display("%0t no_pixels: expected %0b, got %0b", $time,
							want_measure.no_pixels, got_measure.no_pixels);
						errors++;
					end
				end
			end
		end
	end

	// watchdog: cycles in a row with no item moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			quiet_count <= 0;
		else
			quiet_count <= quiet_count + 1;
		if (quiet_count >= WATCHDOG_LIMIT) begin
			$display("FAIL mask_occlusion_and_clip_measure_unit");
			$finish;
		end
	end

endmodule
